// ===== rtl/round_robin_task_slot_scheduler_unit_defines.svh =====
// Assertion macros for the round-robin task slot scheduler
`ifndef ROUND_ROBIN_TASK_SLOT_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_TASK_SLOT_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define RRTS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rrts_pkg.sv =====
// Package: types, codes and helpers of the round-robin task slot scheduler
`timescale 1ns / 1ps
package rrts_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int IDX_W      = 4;
  localparam int ADDR_W     = 48;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int WIDE_W     = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

  localparam logic [OP_W-1:0] OP_SPAWN  = 2'd0;
  localparam logic [OP_W-1:0] OP_SWITCH = 2'd1;
  localparam logic [OP_W-1:0] OP_EXIT   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_READY   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NO_CURRENT = 2'd3;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_RUNNING = 2'd2,
    SLOT_EXITED  = 2'd3
  } slot_state_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] entry_address;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    task_index;
    logic [ADDR_W-1:0]   task_entry;
    logic                switched;
  } out_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
  } sts_t;

  function automatic logic [IDX_W-1:0] to_index(input logic [SLOT_W-1:0] slot);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(slot);
    return wide[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/round_robin_task_slot_scheduler_unit.sv =====
// Top level of the round-robin task slot scheduler.
// An accepted transaction is captured into the operand registers, then committed
// to the slot table and the output register; the commit waits while an earlier
// result is still pending. The slot search is combinational; the controller holds
// one transaction at a time and takes no new one until the last is committed.
// Reset: synchronous; all slots empty, no current task, no result pending.
`timescale 1ns / 1ps
`include "round_robin_task_slot_scheduler_unit_defines.svh"
module round_robin_task_slot_scheduler_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rrts_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rrts_pkg::out_t out_data
);

  rrts_pkg::cmd_t cmd;
  rrts_pkg::sts_t sts;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrts_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_data (out_data)
  );

  assign out_valid = sts.out_valid;

  `RRTS_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready, "transaction accepted while busy")
  `RRTS_ASSERT_SAME(a_fail_clean, clk, rst, out_valid && (out_data.status != rrts_pkg::STATUS_OK), (out_data.task_index == '0) && (out_data.task_entry == '0) && !out_data.switched, "failed result carries data")
  `RRTS_ASSERT_SAME(a_switch_ok, clk, rst, out_valid && out_data.switched, out_data.status == rrts_pkg::STATUS_OK, "switch reported with error status")
  `RRTS_ASSERT_SAME(a_result_source, clk, rst, out_valid && !$past(out_valid), !$past(in_ready), "result without a transaction in work")

endmodule

// ===== rtl/rrts_datapath.sv =====
// Datapath: slot table, entry memory, slot search and result register
`timescale 1ns / 1ps
module rrts_datapath (
  input  logic          clk,
  input  logic          rst,
  input  rrts_pkg::cmd_t cmd,
  output rrts_pkg::sts_t sts,
  input  rrts_pkg::in_t  in_data,
  output rrts_pkg::out_t out_data
);

  rrts_pkg::slot_state_t             slot_state [rrts_pkg::TASK_SLOTS];
  logic [rrts_pkg::ADDR_W-1:0]       slot_entry [rrts_pkg::TASK_SLOTS];
  logic                              cur_valid;
  logic [rrts_pkg::SLOT_W-1:0]       cur_slot;

  logic [rrts_pkg::OP_W-1:0]         op;
  logic [rrts_pkg::ADDR_W-1:0]       addr;

  logic                              free_found;
  logic [rrts_pkg::SLOT_W-1:0]       free_idx;
  logic                              ready_found;
  logic [rrts_pkg::SLOT_W-1:0]       ready_idx;
  logic [rrts_pkg::SLOT_W-1:0]       start;
  logic [rrts_pkg::SLOT_W:0]         pos;

  logic [rrts_pkg::STATUS_W-1:0]     res_status;
  logic [rrts_pkg::IDX_W-1:0]        res_index;
  logic                              res_switched;

  logic                              out_valid;
  logic [rrts_pkg::STATUS_W-1:0]     out_status;
  logic [rrts_pkg::IDX_W-1:0]        out_index;
  logic                              out_switched;
  logic [rrts_pkg::ADDR_W-1:0]       rdata;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op   <= in_data.operation;
      addr <= in_data.entry_address;
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = rrts_pkg::TASK_SLOTS - 1; i >= 0; i--) begin
      if (slot_state[i] == rrts_pkg::SLOT_EMPTY || slot_state[i] == rrts_pkg::SLOT_EXITED) begin
        free_found = 1'b1;
        free_idx   = rrts_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    if (!cur_valid || cur_slot == rrts_pkg::LAST_SLOT) begin
      start = '0;
    end else begin
      start = cur_slot + 1'b1;
    end
  end

  always_comb begin
    ready_found = 1'b0;
    ready_idx   = '0;
    pos         = '0;
    for (int k = rrts_pkg::TASK_SLOTS - 1; k >= 0; k--) begin
      pos = {1'b0, start} + (rrts_pkg::SLOT_W + 1)'(k);
      if (pos >= (rrts_pkg::SLOT_W + 1)'(rrts_pkg::TASK_SLOTS)) begin
        pos = pos - (rrts_pkg::SLOT_W + 1)'(rrts_pkg::TASK_SLOTS);
      end
      if (slot_state[pos[rrts_pkg::SLOT_W-1:0]] == rrts_pkg::SLOT_READY) begin
        ready_found = 1'b1;
        ready_idx   = pos[rrts_pkg::SLOT_W-1:0];
      end
    end
  end

  always_comb begin
    res_status   = rrts_pkg::STATUS_OK;
    res_index    = '0;
    res_switched = 1'b0;
    unique case (op)
      rrts_pkg::OP_SPAWN: begin
        if (free_found) begin
          res_index = rrts_pkg::to_index(free_idx);
        end else begin
          res_status = rrts_pkg::STATUS_NO_FREE;
        end
      end
      rrts_pkg::OP_SWITCH: begin
        if (ready_found) begin
          res_index    = rrts_pkg::to_index(ready_idx);
          res_switched = 1'b1;
        end else begin
          res_status = rrts_pkg::STATUS_NO_READY;
        end
      end
      rrts_pkg::OP_EXIT: begin
        if (!cur_valid) begin
          res_status = rrts_pkg::STATUS_NO_CURRENT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rrts_pkg::TASK_SLOTS; i++) begin
        slot_state[i] <= rrts_pkg::SLOT_EMPTY;
      end
      cur_valid <= 1'b0;
      cur_slot  <= '0;
    end else if (cmd.commit) begin
      unique case (op)
        rrts_pkg::OP_SPAWN: begin
          if (free_found) begin
            slot_state[free_idx] <= rrts_pkg::SLOT_READY;
          end
        end
        rrts_pkg::OP_SWITCH: begin
          if (ready_found) begin
            if (cur_valid) begin
              slot_state[cur_slot] <= rrts_pkg::SLOT_READY;
            end
            slot_state[ready_idx] <= rrts_pkg::SLOT_RUNNING;
            cur_slot  <= ready_idx;
            cur_valid <= 1'b1;
          end
        end
        rrts_pkg::OP_EXIT: begin
          if (cur_valid) begin
            slot_state[cur_slot] <= rrts_pkg::SLOT_EXITED;
            cur_valid <= 1'b0;
            cur_slot  <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && op == rrts_pkg::OP_SPAWN && free_found) begin
      slot_entry[free_idx] <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && op == rrts_pkg::OP_SWITCH && ready_found) begin
      rdata <= slot_entry[ready_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (cmd.pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status   <= res_status;
      out_index    <= res_index;
      out_switched <= res_switched;
    end
  end

  assign sts.out_valid       = out_valid;
  assign out_data.status     = out_status;
  assign out_data.task_index = out_index;
  assign out_data.task_entry = out_switched ? rdata : '0;
  assign out_data.switched   = out_switched;

endmodule

// ===== rtl/rrts_ctrl.sv =====
// Controller: state machine that sequences capture, commit and result handoff
`timescale 1ns / 1ps
module rrts_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  input  rrts_pkg::sts_t sts,
  output rrts_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_ready && in_valid;
  assign cmd.commit  = (state == S_EXEC) && (!sts.out_valid || out_ready);
  assign cmd.pop     = sts.out_valid && out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.capture) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
